// ===== hw/rtl/cpqm_pkg.sv =====
package cpqm_pkg;

  localparam int IN_BYTES  = 23;
  localparam int OUT_BYTES = 16;
  localparam int GAIN_W    = 48;
  localparam int LIM_W     = 31;
  localparam int FLY_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_N     = 49;

  localparam logic [2:0] REG_PITCH_ANGLE_GAINS = 3'd0;
  localparam logic [2:0] REG_ROLL_ANGLE_GAINS  = 3'd1;
  localparam logic [2:0] REG_PITCH_RATE_GAINS  = 3'd2;
  localparam logic [2:0] REG_ROLL_RATE_GAINS   = 3'd3;
  localparam logic [2:0] REG_ANGLE_INT_LIMIT   = 3'd4;
  localparam logic [2:0] REG_RATE_INT_LIMIT    = 3'd5;
  localparam logic [2:0] REG_FLY_THROTTLE      = 3'd6;

  localparam logic [30:0] ANGLE_LIMIT_RESET = 31'd327680;
  localparam logic [30:0] RATE_LIMIT_RESET  = 31'd1966080;
  localparam logic [6:0]  FLY_RESET         = 7'd20;

  localparam logic [31:0] DT_FIRST   = 32'd655;
  localparam logic [11:0] DB_LO      = 12'd1900;
  localparam logic [11:0] DB_HI      = 12'd2100;
  localparam logic [11:0] STICK_MID  = 12'd2000;
  // 2^19 / 40 rounded up, quotient in bits 25:19
  localparam logic [25:0] THR_RECIP      = 26'd13108;
  // 196608 / 200 = 983 rest 8, so the fraction is (2|d| + 25) / 50
  localparam logic [22:0] TGT_WHOLE      = 23'd983;
  localparam logic [13:0] TGT_FRAC_BIAS  = 14'd25;
  // 2^18 / 50 rounded up, quotient in bits 26:18
  localparam logic [26:0] TGT_FRAC_RECIP = 27'd5243;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/cascaded_pid_quad_mixer.sv =====
// channel  dir  signals                       beat contents
// s        in   s_tvalid s_tready s_tdata/user one control tick of sensor and stick values
// m        out  m_tvalid m_tready m_tdata/user four motor duties and the idle flag
// cfg      in   cfg_we cfg_index cfg_data     one register write, no wait
//
// a tick runs from accept through the steps below to the mix state, which registers
// the result beat; only then can the next tick be accepted. throttle and both targets
// come from constant reciprocal products; each pid steps through error, derivative
// setup, the shared restoring divider (skipped when the step is zero), the multiply
// states S_M0 to S_M4 on the shared 33x33 multiplier for four products, and the integral.
// s_tready is high only when the sequencer is idle; a finished beat waits in the output
// register, and a following tick can run meanwhile but holds at the end until it drains.
// rst is synchronous; it clears sequencer, pid state and gains and presets limits and fly.
module cascaded_pid_quad_mixer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rc_throttle[11:0] rc_pitch[23:12] rc_roll[35:24] roll_angle[60:36]
  // pitch_angle[85:61] roll_rate[117:86] pitch_rate[149:118] now_time[181:150]
  input  logic [cpqm_pkg::IN_BYTES*8-1:0] s_tdata,
  // integral_lock[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // motor_front_a[31:0] motor_front_b[63:32] motor_rear_a[95:64] motor_rear_b[127:96]
  output logic [cpqm_pkg::OUT_BYTES*8-1:0] m_tdata,
  // above_idle[0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [cpqm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpqm_pkg::GAIN_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_THR, S_TGT, S_ERR, S_DER, S_DERW,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_INT, S_MIX
  } state_t;

  state_t state;

  logic [cpqm_pkg::GAIN_W-1:0] gains [4];
  logic [cpqm_pkg::LIM_W-1:0]  alim, rlim;
  logic [cpqm_pkg::FLY_W-1:0]  fly;

  logic signed [31:0] perr [4];
  logic signed [31:0] isum [4];
  logic [31:0]        last_time;

  logic [11:0]        thr_raw, dp, dr;
  logic signed [31:0] meas [4];
  logic signed [31:0] tgt [4];
  logic [31:0]        dt;
  logic               lock;
  logic [6:0]         thr_pct;
  logic [1:0]         k;
  logic               tsel, neg;
  logic signed [31:0] err, der, outv, pr, rr;
  logic signed [51:0] acc;

  logic [48:0] div_q;
  logic [31:0] div_r, div_d;
  logic [5:0]  div_cnt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // deadband on incoming sticks
  logic [11:0] in_p, in_r, in_p_db, in_r_db;
  assign in_p = s_tdata[23:12];
  assign in_r = s_tdata[35:24];
  assign in_p_db = (in_p > cpqm_pkg::DB_LO && in_p < cpqm_pkg::DB_HI) ? cpqm_pkg::STICK_MID : in_p;
  assign in_r_db = (in_r > cpqm_pkg::DB_LO && in_r < cpqm_pkg::DB_HI) ? cpqm_pkg::STICK_MID : in_r;

  // divider step
  logic [32:0] rem_sh;
  logic        dge;
  assign rem_sh = {div_r, div_q[48]};
  assign dge    = rem_sh >= {1'b0, div_d};

  // throttle percent
  logic [25:0] thr_prod;
  assign thr_prod = {14'd0, thr_raw} * cpqm_pkg::THR_RECIP;

  // target magnitude: 983 |d| plus (2|d| + 25) / 50
  logic [11:0]        stick;
  logic signed [13:0] sd;
  logic [12:0]        smag;
  logic [22:0]        tgt_whole, tgt_mag;
  logic [13:0]        tgt_fy;
  logic [26:0]        tgt_fp;
  assign stick     = tsel ? dr : dp;
  assign sd        = $signed({2'b00, stick}) - $signed({2'b00, cpqm_pkg::STICK_MID});
  assign smag      = sd[13] ? 13'(-sd) : 13'(sd);
  assign tgt_whole = {10'd0, smag} * cpqm_pkg::TGT_WHOLE;
  assign tgt_fy    = {smag, 1'b0} + cpqm_pkg::TGT_FRAC_BIAS;
  assign tgt_fp    = {13'd0, tgt_fy} * cpqm_pkg::TGT_FRAC_RECIP;
  assign tgt_mag   = tgt_whole + {14'd0, tgt_fp[26:18]};

  // pid terms
  logic [15:0] gp, gi, gd;
  assign gp = gains[k][15:0];
  assign gi = gains[k][31:16];
  assign gd = gains[k][47:32];

  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  assign diff     = {err[31], err} - {perr[k][31], perr[k]};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

  logic signed [32:0] e33;
  assign e33 = {tgt[k][31], tgt[k]} - {meas[k][31], meas[k]};

  logic signed [49:0] der_full;
  assign der_full = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M0: begin mul_a = {err[31], err};         mul_b = $signed({17'd0, gp}); end
      S_M1: begin mul_a = {isum[k][31], isum[k]}; mul_b = $signed({17'd0, gi}); end
      S_M2: begin mul_a = {der[31], der};         mul_b = $signed({17'd0, gd}); end
      S_M4: begin mul_a = {err[31], err};         mul_b = $signed({1'b0, dt}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // integral update
  logic [32:0]        omag;
  logic signed [31:0] cand;
  logic [30:0]        lim;
  logic signed [32:0] lims, cand33, out33;
  logic               in_win;
  assign omag   = outv[31] ? 33'(-{outv[31], outv}) : {1'b0, outv};
  assign cand   = cpqm_pkg::sat32(66'(isum[k]) + (prod >>> 16));
  assign lim    = k[1] ? rlim : alim;
  assign lims   = $signed({2'b00, lim});
  assign cand33 = {cand[31], cand};
  assign out33  = {outv[31], outv};
  assign in_win = cand33 > -lims && cand33 < lims && out33 > -lims && out33 < lims;

  // mixer
  logic signed [34:0] thrq, pr35, rr35;
  assign thrq = $signed({12'd0, thr_pct, 16'd0});
  assign pr35 = 35'(pr);
  assign rr35 = 35'(rr);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      div_cnt   <= '0;
      gains[0]  <= '0;
      gains[1]  <= '0;
      gains[2]  <= '0;
      gains[3]  <= '0;
      alim      <= cpqm_pkg::ANGLE_LIMIT_RESET;
      rlim      <= cpqm_pkg::RATE_LIMIT_RESET;
      fly       <= cpqm_pkg::FLY_RESET;
      for (int i = 0; i < 4; i++) begin
        perr[i] <= '0;
        isum[i] <= '0;
      end
      last_time <= '0;
      k         <= '0;
      tsel      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cpqm_pkg::REG_PITCH_ANGLE_GAINS: gains[0] <= cfg_data;
          cpqm_pkg::REG_ROLL_ANGLE_GAINS:  gains[1] <= cfg_data;
          cpqm_pkg::REG_PITCH_RATE_GAINS:  gains[2] <= cfg_data;
          cpqm_pkg::REG_ROLL_RATE_GAINS:   gains[3] <= cfg_data;
          cpqm_pkg::REG_ANGLE_INT_LIMIT:   alim <= cfg_data[30:0];
          cpqm_pkg::REG_RATE_INT_LIMIT:    rlim <= cfg_data[30:0];
          cpqm_pkg::REG_FLY_THROTTLE:      fly  <= cfg_data[6:0];
          default: ;
        endcase
      end

      // the mix state sets valid itself when the register frees up
      if (m_tvalid && m_tready && state != S_MIX) m_tvalid <= 1'b0;

      if (div_cnt != '0) begin
        div_r   <= dge ? 32'(rem_sh - {1'b0, div_d}) : rem_sh[31:0];
        div_q   <= {div_q[47:0], dge};
        div_cnt <= div_cnt - 6'd1;
      end

      prod <= mul_a * mul_b;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            thr_raw   <= s_tdata[11:0];
            dp        <= in_p_db;
            dr        <= in_r_db;
            meas[0]   <= 32'(signed'(s_tdata[85:61]));
            meas[1]   <= 32'(signed'(s_tdata[60:36]));
            meas[2]   <= s_tdata[149:118];
            meas[3]   <= s_tdata[117:86];
            lock      <= s_tuser[0];
            dt        <= (last_time == '0) ? cpqm_pkg::DT_FIRST : s_tdata[181:150] - last_time;
            last_time <= s_tdata[181:150];
            state     <= S_THR;
          end
        end
        S_THR: begin
          thr_pct <= thr_prod[25:19];
          tsel    <= 1'b0;
          state   <= S_TGT;
        end
        S_TGT: begin
          // |d| * 3 * 65536 / 200 rounded half away from zero
          tgt[{1'b0, tsel}] <= sd[13] ? -$signed({9'd0, tgt_mag}) : $signed({9'd0, tgt_mag});
          if (!tsel) begin
            tsel  <= 1'b1;
          end else begin
            k     <= '0;
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err   <= cpqm_pkg::sat32(66'(e33));
          state <= S_DER;
        end
        S_DER: begin
          if (dt == '0) begin
            der   <= '0;
            state <= S_M0;
          end else begin
            div_q   <= {diff_mag, 16'd0};
            div_r   <= '0;
            div_d   <= dt;
            div_cnt <= 6'(cpqm_pkg::DIV_N);
            neg     <= diff[32];
            state   <= S_DERW;
          end
        end
        S_DERW: begin
          if (div_cnt == '0) begin
            der   <= cpqm_pkg::sat32(66'(der_full));
            state <= S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          acc   <= prod[51:0];
          state <= S_M2;
        end
        S_M2: begin
          acc   <= acc + prod[51:0];
          state <= S_M3;
        end
        S_M3: begin
          acc   <= acc + prod[51:0];
          state <= S_M4;
        end
        S_M4: begin
          outv  <= cpqm_pkg::sat32(66'(acc >>> 8));
          state <= S_INT;
        end
        S_INT: begin
          perr[k] <= err;
          if (lock) isum[k] <= '0;
          else if (omag < {10'd0, thr_pct, 16'd0} && in_win) isum[k] <= cand;
          if (!k[1]) tgt[{1'b1, k[0]}] <= outv;
          else if (!k[0]) pr <= outv;
          else rr <= outv;
          if (k == 2'd3) state <= S_MIX;
          else begin
            k     <= k + 2'd1;
            state <= S_ERR;
          end
        end
        S_MIX: begin
          if (!m_tvalid || m_tready) begin
            if ({1'b0, thr_pct} > {1'b0, fly}) begin
              m_tdata[31:0]   <= cpqm_pkg::sat32(66'(thrq - rr35 + pr35));
              m_tdata[63:32]  <= cpqm_pkg::sat32(66'(thrq - rr35 - pr35));
              m_tdata[95:64]  <= cpqm_pkg::sat32(66'(thrq + rr35 + pr35));
              m_tdata[127:96] <= cpqm_pkg::sat32(66'(thrq + rr35 - pr35));
              m_tuser[0]      <= 1'b1;
            end else begin
              for (int j = 0; j < 4; j++) m_tdata[j*32 +: 32] <= {9'd0, fly, 16'd0};
              m_tuser[0] <= 1'b0;
            end
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (state == S_DERW))
    else $error("divider running outside a wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after accepting a tick");

  a_idle_equal: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == m_tdata[63:32] &&
                                   m_tdata[95:64] == m_tdata[127:96]))
    else $error("idle beat with unequal motor duties");

endmodule

// ===== test/cascaded_pid_quad_mixer_test.sv =====
`timescale 1ns / 1ps

module cascaded_pid_quad_mixer_test;

  typedef struct packed {
    logic [11:0]        thr;
    logic [11:0]        stk_pitch;
    logic [11:0]        stk_roll;
    logic signed [24:0] roll_ang;
    logic signed [24:0] pitch_ang;
    logic signed [31:0] roll_rt;
    logic signed [31:0] pitch_rt;
    logic [31:0]        now;
    logic               lock;
  } tick_t;

  typedef struct {
    logic [31:0] motor [4];
    logic        above;
  } duty_t;

  typedef struct {
    tick_t       t;
    bit          typed;
    logic [31:0] duty;
    logic        above;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [cpqm_pkg::IN_BYTES*8-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [cpqm_pkg::OUT_BYTES*8-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we = 0;
  logic [cpqm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cpqm_pkg::GAIN_W-1:0] cfg_data = '0;

  cascaded_pid_quad_mixer u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // controller copy: registers and loop state
  logic [47:0] gains [4];
  logic [30:0] angle_lim, rate_lim;
  logic [6:0]  fly_pct;
  int          prev_err [4];
  int          integ [4];
  logic [31:0] last_now;

  duty_t duty_q [$];
  int    errors = 0;
  int    idle_cycles = 0;
  logic [31:0] clock_now = 0;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint floor_div(longint v, longint d);
    longint q;
    q = v / d;
    if (v % d != 0 && v < 0) q--;
    return q;
  endfunction

  function automatic int stick_angle(logic [11:0] c);
    longint v;
    if (c > cpqm_pkg::DB_LO && c < cpqm_pkg::DB_HI) c = cpqm_pkg::STICK_MID;
    v = (longint'(c) - 2000) * 196608;
    if (v >= 0) return int'((v + 100) / 200);
    return int'(-((-v + 100) / 200));
  endfunction

  function automatic int pid(int k, logic [47:0] g, logic [30:0] lim, int tgt, int meas,
                             longint thr, logic [31:0] dt, logic lock);
    longint acc, mag, l;
    int e, der, o, cand;
    e = sat(longint'(tgt) - longint'(meas));
    der = 0;
    if (dt != 0)
      der = sat(((longint'(e) - longint'(prev_err[k])) * 65536) / longint'(dt));
    acc = longint'(g[15:0]) * e + longint'(g[31:16]) * integ[k] + longint'(g[47:32]) * der;
    o = sat(floor_div(acc, 256));
    prev_err[k] = e;
    if (lock) begin
      integ[k] = 0;
    end else begin
      mag = o < 0 ? -longint'(o) : longint'(o);
      if (mag < thr) begin
        cand = sat(longint'(integ[k]) + floor_div(longint'(e) * longint'(dt), 65536));
        l = longint'(lim);
        if (cand > -l && cand < l && o > -l && o < l) integ[k] = cand;
      end
    end
    return o;
  endfunction

  function automatic duty_t mix_tick(tick_t t);
    duty_t d;
    longint thr;
    logic [31:0] dt;
    int pa, ra, pr, rr;
    thr = longint'(t.thr / 40) * 65536;
    dt = (last_now == 0) ? cpqm_pkg::DT_FIRST : t.now - last_now;
    last_now = t.now;
    pa = pid(0, gains[0], angle_lim, stick_angle(t.stk_pitch), t.pitch_ang, thr, dt, t.lock);
    ra = pid(1, gains[1], angle_lim, stick_angle(t.stk_roll), t.roll_ang, thr, dt, t.lock);
    pr = pid(2, gains[2], rate_lim, pa, t.pitch_rt, thr, dt, t.lock);
    rr = pid(3, gains[3], rate_lim, ra, t.roll_rt, thr, dt, t.lock);
    if (t.thr / 40 > fly_pct) begin
      d.motor[0] = sat(thr - rr + pr);
      d.motor[1] = sat(thr - rr - pr);
      d.motor[2] = sat(thr + rr + pr);
      d.motor[3] = sat(thr + rr - pr);
      d.above = 1;
    end else begin
      for (int j = 0; j < 4; j++) d.motor[j] = {9'd0, fly_pct, 16'd0};
      d.above = 0;
    end
    return d;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      cpqm_pkg::REG_PITCH_ANGLE_GAINS: gains[0] = v;
      cpqm_pkg::REG_ROLL_ANGLE_GAINS:  gains[1] = v;
      cpqm_pkg::REG_PITCH_RATE_GAINS:  gains[2] = v;
      cpqm_pkg::REG_ROLL_RATE_GAINS:   gains[3] = v;
      cpqm_pkg::REG_ANGLE_INT_LIMIT:   angle_lim = v[30:0];
      cpqm_pkg::REG_RATE_INT_LIMIT:    rate_lim = v[30:0];
      cpqm_pkg::REG_FLY_THROTTLE:      fly_pct = v[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [47:0] soft_gains();
    return {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 256)),
            16'($urandom_range(0, 1024))};
  endfunction

  task automatic send_tick(tick_t t, bit typed, logic [31:0] duty, logic above);
    duty_t d;
    int g;
    g = ($urandom_range(0, 3) == 0) ? 0 :
        ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {2'b00, t.now, t.pitch_rt, t.roll_rt, t.pitch_ang, t.roll_ang,
                t.stk_roll, t.stk_pitch, t.thr};
    s_tuser <= t.lock;
    do @(posedge clk); while (!s_tready);
    d = mix_tick(t);
    if (typed) begin
      for (int j = 0; j < 4; j++) d.motor[j] = duty;
      d.above = above;
    end
    duty_q.push_back(d);
  endtask

  function automatic logic [11:0] pick_stick();
    case ($urandom_range(0, 4))
      0: return 12'($urandom_range(1895, 2105));
      1: return ($urandom_range(0, 1) != 0) ? 12'd0 : 12'd4000;
      default: return 12'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic int pick_rate();
    if ($urandom_range(0, 9) == 0) return int'($urandom);
    return int'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.thr = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 1000))
                                        : 12'($urandom_range(0, 4000));
    t.stk_pitch = pick_stick();
    t.stk_roll = pick_stick();
    t.roll_ang = 25'(int'($urandom_range(0, 23592960)) - 11796480);
    t.pitch_ang = 25'(int'($urandom_range(0, 23592960)) - 11796480);
    t.roll_rt = pick_rate();
    t.pitch_rt = pick_rate();
    case ($urandom_range(0, 19))
      0: ;                                 // same time again, zero step
      1: clock_now = 0;
      2, 3: clock_now = $urandom;
      default: clock_now = clock_now + $urandom_range(300, 1500);
    endcase
    t.now = clock_now;
    t.lock = ($urandom_range(0, 9) == 0);
    return t;
  endfunction

  row_t rows [12];

  initial begin
    gains = '{default: '0};
    angle_lim = cpqm_pkg::ANGLE_LIMIT_RESET;
    rate_lim = cpqm_pkg::RATE_LIMIT_RESET;
    fly_pct = cpqm_pkg::FLY_RESET;
    prev_err = '{default: 0};
    integ = '{default: 0};
    last_now = 0;

    // all gains zero after reset, so duties are plain throttle or idle level
    rows[0]  = '{'{12'd4000, 12'd2000, 12'd2000, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'd0, 1'b0}, 1, 32'd6553600, 1'b1};
    rows[1]  = '{'{12'd0, 12'd0, 12'd4000, 25'sd11796480, -25'sd11796480,
                   32'sh7fffffff, 32'sh80000000, 32'd655, 1'b0}, 1, 32'd1310720, 1'b0};
    rows[2]  = '{'{12'd840, 12'd1900, 12'd2100, -25'sd11796480, 25'sd11796480,
                   32'sh80000000, 32'sh7fffffff, 32'd1000, 1'b0}, 1, 32'd1376256, 1'b1};
    rows[3]  = '{'{12'd839, 12'd1901, 12'd2099, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'd1000, 1'b0}, 1, 32'd1310720, 1'b0};
    rows[4]  = '{'{12'd4000, 12'd4000, 12'd0, 25'sd65536, -25'sd65536, 32'sd1, -32'sd1,
                   32'd2000, 1'b1}, 0, '0, 1'b0};
    rows[5]  = '{'{12'd2000, 12'd2099, 12'd1901, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'd0, 1'b0}, 0, '0, 1'b0};
    rows[6]  = '{'{12'd3000, 12'd2100, 12'd1900, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'hffffffff, 1'b0}, 0, '0, 1'b0};
    rows[7]  = '{'{12'd3000, 12'd0, 12'd4000, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'h00000001, 1'b0}, 0, '0, 1'b0};
    rows[8]  = '{'{12'd4095 & 12'd4000, 12'd4000, 12'd0, 25'sd100, 25'sd200,
                   32'sd5, 32'sd7, 32'h00000001, 1'b0}, 0, '0, 1'b0};
    rows[9]  = '{'{12'd1234, 12'd1500, 12'd2500, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'hfffffffe, 1'b1}, 0, '0, 1'b0};
    rows[10] = '{'{12'd40, 12'd2000, 12'd2000, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'd0, 1'b0}, 1, 32'd1310720, 1'b0};
    rows[11] = '{'{12'd4000, 12'd2000, 12'd2000, 25'sd0, 25'sd0, 32'sd0, 32'sd0,
                   32'd655, 1'b0}, 1, 32'd6553600, 1'b1};

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send_tick(rows[i].t, rows[i].typed, rows[i].duty, rows[i].above);

    for (int ph = 0; ph < 8; ph++) begin
      // registers only change once the pipeline has drained
      s_tvalid <= 0;
      while (duty_q.size() != 0) @(posedge clk);
      repeat (20) @(posedge clk);
      case (ph)
        0: ;
        1: begin
          for (int k = 0; k < 4; k++) write_reg(3'(k), soft_gains());
          write_reg(cpqm_pkg::REG_ANGLE_INT_LIMIT, 48'(cpqm_pkg::ANGLE_LIMIT_RESET));
          write_reg(cpqm_pkg::REG_RATE_INT_LIMIT, 48'(cpqm_pkg::RATE_LIMIT_RESET));
          write_reg(cpqm_pkg::REG_FLY_THROTTLE, 48'd20);
        end
        2: begin
          for (int k = 0; k < 4; k++) write_reg(3'(k), 48'hffff_ffff_ffff);
          write_reg(cpqm_pkg::REG_ANGLE_INT_LIMIT, 48'h7fff_ffff);
          write_reg(cpqm_pkg::REG_RATE_INT_LIMIT, 48'h7fff_ffff);
          write_reg(cpqm_pkg::REG_FLY_THROTTLE, 48'd0);
        end
        3: begin
          for (int k = 0; k < 4; k++) write_reg(3'(k), soft_gains());
          write_reg(cpqm_pkg::REG_ANGLE_INT_LIMIT, 48'd0);
          write_reg(cpqm_pkg::REG_RATE_INT_LIMIT, 48'd0);
          write_reg(cpqm_pkg::REG_FLY_THROTTLE, 48'd100);
        end
        default: begin
          for (int k = 0; k < 4; k++)
            write_reg(3'(k), ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                                                          : soft_gains());
          write_reg(cpqm_pkg::REG_ANGLE_INT_LIMIT, 48'($urandom_range(0, 4000000)));
          write_reg(cpqm_pkg::REG_RATE_INT_LIMIT, 48'($urandom_range(0, 20000000)));
          write_reg(cpqm_pkg::REG_FLY_THROTTLE, 48'($urandom_range(0, 40)));
        end
      endcase
      cfg_we <= 0;
      for (int n = 0; n < 100; n++) send_tick(random_tick(), 0, '0, 1'b0);
    end

    s_tvalid <= 0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver stalls: mostly short, a few long, some stretches always ready
  initial begin
    int on, off, mode;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 9);
      on = (mode < 2) ? $urandom_range(50, 400) : $urandom_range(1, 8);
      off = (mode == 9) ? $urandom_range(30, 400) : $urandom_range(1, 5);
      m_tready <= 1;
      repeat (on) @(posedge clk);
      m_tready <= 0;
      repeat (off) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    duty_t d;
    if (!rst && m_tvalid && m_tready) begin
      if (duty_q.size() == 0) begin
        $display("%0t: unexpected beat %h / %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        d = duty_q.pop_front();
        for (int j = 0; j < 4; j++)
          if (m_tdata[32*j +: 32] !== d.motor[j]) begin
            $display("%0t: motor %0d expected %h actual %h", $time, j, d.motor[j],
                     m_tdata[32*j +: 32]);
            errors++;
          end
        if (m_tuser[0] !== d.above) begin
          $display("%0t: above_idle expected %b actual %b", $time, d.above, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
